/* hw/rtl/msd_pkg.sv */
// Shared constants, types and a helper for the smoothed mid/side decoder.
`timescale 1ns / 1ps
`default_nettype none

package msd_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 24;

  // Gains are unsigned Q2.14, ramp accumulators unsigned Q2.30.
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned GAIN_FRAC = 14;
  localparam int unsigned CUR_W     = 32;
  localparam int unsigned STEPS_W   = 12;

  // Multiplier consumes this many gain bits per cycle.
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned MUL_STEPS  = GAIN_W / DIGIT_W;
  localparam int unsigned ROUND_BIAS = 1 << (GAIN_FRAC - 1);

  // Guard bits above the sample width for the intermediate sums.
  localparam int unsigned HEADROOM_W = 8;

  localparam int unsigned NUM_RAMPS   = 3;
  localparam int unsigned RAMP_IDX_W  = 2;
  localparam logic [RAMP_IDX_W-1:0] RAMP_WIDTH = 2'd0;
  localparam logic [RAMP_IDX_W-1:0] RAMP_MUTE  = 2'd1;
  localparam logic [RAMP_IDX_W-1:0] RAMP_SWAP  = 2'd2;

  localparam logic [GAIN_W-1:0]  GAIN_ZERO        = 16'd0;
  localparam logic [GAIN_W-1:0]  GAIN_ONE         = 16'd16384;
  localparam logic [GAIN_W-1:0]  WIDTH_RESET      = 16'd5734;
  localparam logic [STEPS_W-1:0] RAMP_STEPS_RESET = 12'd720;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AIM,
    ST_DIV,
    ST_ADV,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_MUL4,
    ST_OUT
  } msd_state_e;

  // Places a Q2.14 gain into the Q2.30 accumulator format.
  function automatic logic [CUR_W-1:0] to_cur(input logic [GAIN_W-1:0] g);
    to_cur = {g, {(CUR_W - GAIN_W){1'b0}}};
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/msd_div.sv */
// Radix-2 restoring divider for the ramp step, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module msd_div import msd_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic signed [CUR_W:0]   dividend_i,
  input  wire logic [STEPS_W-1:0]      divisor_i,
  output logic                         done_o,
  output logic [CUR_W-1:0]             quot_o
);

  localparam int unsigned CNT_W = $clog2(CUR_W);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               neg_q;
  logic [CUR_W-1:0]   num_q;
  logic [STEPS_W-1:0] rem_q;
  logic [STEPS_W-1:0] div_q;

  logic [CUR_W-1:0]   mag;
  logic [STEPS_W:0]   rem_trial;
  logic               fits;

  // The dividend never exceeds 2^32 - 1 in magnitude, so 32 bits hold it.
  assign mag = dividend_i[CUR_W] ? CUR_W'(-dividend_i) : CUR_W'(dividend_i);

  assign rem_trial = {rem_q, num_q[CUR_W-1]};
  assign fits      = (rem_trial >= {1'b0, div_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(CUR_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Quotient bits shift into the dividend register as it empties.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[CUR_W];
      num_q <= mag;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      num_q <= {num_q[CUR_W-2:0], fits};
      rem_q <= fits ? STEPS_W'(rem_trial - {1'b0, div_q}) : rem_trial[STEPS_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? (~num_q + 1'b1) : num_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |-> !busy_q)
    else $error("divider restarted while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q)
    else $error("divider done while still iterating");
  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |-> divisor_i != '0)
    else $error("divider started with zero divisor");

endmodule

`default_nettype wire

/* hw/rtl/msd_mul.sv */
// Digit-serial signed by Q2.14 multiplier with round-half-up and floor shift.
`timescale 1ns / 1ps
`default_nettype none

module msd_mul import msd_pkg::*; #(
  parameter int unsigned DATA_W = SAMPLE_BITS_DEF + HEADROOM_W
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic signed [DATA_W-1:0] a_i,
  input  wire logic [GAIN_W-1:0]        g_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic signed [DATA_W-1:0]      p_o
);

  localparam int unsigned ACC_W = DATA_W + GAIN_W + 1;
  localparam int unsigned CNT_W = $clog2(MUL_STEPS);

  logic                     busy_q, busy_d;
  logic                     done_q, done_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  a_q;
  logic [GAIN_W-1:0]        g_q;

  logic signed [ACC_W+DIGIT_W:0] partial;
  logic signed [ACC_W-1:0]       acc_sum;

  // One gain digit times the already shifted operand.
  assign partial = a_q * $signed({1'b0, g_q[DIGIT_W-1:0]});
  assign acc_sum = acc_q + $signed(partial[ACC_W-1:0]);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(MUL_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // The rounding bias is preloaded so the final shift is a plain floor.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= $signed(ACC_W'(ROUND_BIAS));
      a_q   <= ACC_W'(a_i);
      g_q   <= g_i;
    end else if (busy_q) begin
      acc_q <= acc_sum;
      a_q   <= a_q <<< DIGIT_W;
      g_q   <= g_q >> DIGIT_W;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign p_o    = $signed(acc_q[GAIN_FRAC +: DATA_W]);

endmodule

`default_nettype wire

/* hw/rtl/mid_side_decoder_smoothed.sv */
// Top level of the smoothed mid/side stereo decoder.
//
// Input requests arrive on the s_axis channel: mid and side samples, the
// width target and the swap and side-mute switches in tdata, the mono flag
// in tuser. Each request yields exactly one result on m_axis: left and
// right samples, saturated to SAMPLE_BITS. The ramp length is written
// through cfg_we_i / cfg_wdata_i; the user must write it only while the
// block is idle, as the block itself does not enforce this.
// Sequence: after acceptance the compare step checks the width, mute and
// swap targets in turn, a ramp advance step follows, then four multiplies
// on the shared multiplier, which consumes four gain bits per cycle, and
// an output step. With a nonzero ramp length, every target that changes
// adds a divide for its ramp step, computed by the shared divider at one
// quotient bit per cycle. Mono requests skip the multiplies. One request
// is in work at a time: a new one is taken once the last has reached the
// output register. The output register holds a finished result while
// m_axis_tready is low; the next request can be accepted meanwhile, and
// its result waits until that register frees up.
// Reset sets ramp length 720, width gain 0.35, mute gain 1.0, swap 0, and
// empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module mid_side_decoder_smoothed import msd_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // tdata: mid_sample, side_sample, width_target, swap_on, side_mute_on, zero fill
  input  wire logic [((2*SAMPLE_BITS+GAIN_W+2+7)/8)*8-1:0] s_axis_tdata,
  // tuser: mono_input
  input  wire logic                     s_axis_tuser,
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: left_sample, right_sample, zero fill
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  input  wire logic                     cfg_we_i,
  input  wire logic [STEPS_W-1:0]       cfg_wdata_i
);

  localparam int unsigned S      = SAMPLE_BITS;
  localparam int unsigned W      = SAMPLE_BITS + HEADROOM_W;
  localparam int unsigned OUT_TW = ((2*SAMPLE_BITS+7)/8)*8;

  msd_state_e state_q, state_d;
  logic [RAMP_IDX_W-1:0] k_q, k_d;
  logic launched_q, launched_d;
  logic out_valid_q, out_valid_d;
  logic [STEPS_W-1:0] cfg_q;

  logic [CUR_W-1:0]   cur_q    [NUM_RAMPS];
  logic [CUR_W-1:0]   cur_d    [NUM_RAMPS];
  logic [GAIN_W-1:0]  tgt_st_q [NUM_RAMPS];
  logic [GAIN_W-1:0]  tgt_st_d [NUM_RAMPS];
  logic [CUR_W-1:0]   inc_q    [NUM_RAMPS];
  logic [CUR_W-1:0]   inc_d    [NUM_RAMPS];
  logic [STEPS_W-1:0] rem_q    [NUM_RAMPS];
  logic [STEPS_W-1:0] rem_d    [NUM_RAMPS];

  logic [CUR_W-1:0]   cur_step [NUM_RAMPS];
  logic [GAIN_W-1:0]  adv_gain [NUM_RAMPS];
  logic [GAIN_W-1:0]  gain_q   [NUM_RAMPS];
  logic [GAIN_W-1:0]  tgt_in_q [NUM_RAMPS];

  logic signed [S-1:0] mid_q, side_q;
  logic                mono_q;
  logic signed [W-1:0] p1_q, dl_q, dr_q, lf_q, rf_q;
  logic signed [S-1:0] left_q, right_q;
  logic signed [W-1:0] mid_ext;

  logic in_fire, out_load;

  logic                  div_start, div_done;
  logic signed [CUR_W:0] div_dividend;
  logic [CUR_W-1:0]      div_quot;

  logic                  mul_start, mul_busy, mul_done;
  logic signed [W-1:0]   mul_a, mul_p;
  logic [GAIN_W-1:0]     mul_g;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign mid_ext       = W'(mid_q);

  function automatic logic signed [S-1:0] sat(input logic signed [W-1:0] v);
    logic [W-S:0] top;
    top = v[W-1:S-1];
    if ((&top) || !(|top)) begin
      sat = v[S-1:0];
    end else if (v[W-1]) begin
      sat = {1'b1, {(S-1){1'b0}}};
    end else begin
      sat = {1'b0, {(S-1){1'b1}}};
    end
  endfunction

  // Ramp step of each smoother; the last step lands exactly on the target.
  always_comb begin
    for (int i = 0; i < NUM_RAMPS; i++) begin
      cur_step[i] = cur_q[i] + inc_q[i];
      if (rem_q[i] == '0 || rem_q[i] == STEPS_W'(1)) begin
        adv_gain[i] = tgt_st_q[i];
      end else begin
        adv_gain[i] = cur_step[i][CUR_W-1 -: GAIN_W];
      end
    end
  end

  assign div_dividend = $signed({1'b0, to_cur(tgt_in_q[k_q])}) - $signed({1'b0, cur_q[k_q]});

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    launched_d  = launched_q;
    out_valid_d = out_valid_q;
    cur_d       = cur_q;
    tgt_st_d    = tgt_st_q;
    inc_d       = inc_q;
    rem_d       = rem_q;
    div_start   = 1'b0;
    mul_start   = 1'b0;
    out_load    = 1'b0;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_AIM;
          k_d     = RAMP_WIDTH;
        end
      end
      ST_AIM: begin
        if (tgt_in_q[k_q] != tgt_st_q[k_q]) begin
          tgt_st_d[k_q] = tgt_in_q[k_q];
          if (cfg_q == '0) begin
            cur_d[k_q] = to_cur(tgt_in_q[k_q]);
            inc_d[k_q] = '0;
            rem_d[k_q] = '0;
          end else begin
            rem_d[k_q] = cfg_q;
            div_start  = 1'b1;
          end
        end
        if (div_start) begin
          state_d = ST_DIV;
        end else if (k_q == RAMP_SWAP) begin
          state_d = ST_ADV;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          inc_d[k_q] = div_quot;
          if (k_q == RAMP_SWAP) begin
            state_d = ST_ADV;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = ST_AIM;
          end
        end
      end
      ST_ADV: begin
        for (int i = 0; i < NUM_RAMPS; i++) begin
          if (rem_q[i] != '0) begin
            rem_d[i] = rem_q[i] - 1'b1;
            cur_d[i] = (rem_q[i] == STEPS_W'(1)) ? to_cur(tgt_st_q[i]) : cur_step[i];
          end
        end
        state_d = mono_q ? ST_OUT : ST_MUL1;
      end
      ST_MUL1, ST_MUL2, ST_MUL3, ST_MUL4: begin
        if (!launched_q) begin
          mul_start  = 1'b1;
          launched_d = 1'b1;
        end else if (mul_done) begin
          launched_d = 1'b0;
          unique case (state_q)
            ST_MUL1: state_d = ST_MUL2;
            ST_MUL2: state_d = ST_MUL3;
            ST_MUL3: state_d = ST_MUL4;
            default: state_d = ST_OUT;
          endcase
        end
      end
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_g = '0;
    unique case (state_q)
      ST_MUL1: begin
        mul_a = W'(side_q);
        mul_g = gain_q[RAMP_WIDTH];
      end
      ST_MUL2: begin
        mul_a = p1_q;
        mul_g = gain_q[RAMP_MUTE];
      end
      ST_MUL3: begin
        mul_a = dr_q - dl_q;
        mul_g = gain_q[RAMP_SWAP];
      end
      ST_MUL4: begin
        mul_a = dl_q - dr_q;
        mul_g = gain_q[RAMP_SWAP];
      end
      default: begin
        mul_a = '0;
        mul_g = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= RAMP_WIDTH;
      launched_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cfg_q       <= RAMP_STEPS_RESET;
      cur_q[RAMP_WIDTH]    <= to_cur(WIDTH_RESET);
      cur_q[RAMP_MUTE]     <= to_cur(GAIN_ONE);
      cur_q[RAMP_SWAP]     <= to_cur(GAIN_ZERO);
      tgt_st_q[RAMP_WIDTH] <= WIDTH_RESET;
      tgt_st_q[RAMP_MUTE]  <= GAIN_ONE;
      tgt_st_q[RAMP_SWAP]  <= GAIN_ZERO;
      for (int i = 0; i < NUM_RAMPS; i++) begin
        inc_q[i] <= '0;
        rem_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      launched_q  <= launched_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      cur_q    <= cur_d;
      tgt_st_q <= tgt_st_d;
      inc_q    <= inc_d;
      rem_q    <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mid_q                <= $signed(s_axis_tdata[S-1:0]);
      side_q               <= $signed(s_axis_tdata[2*S-1:S]);
      tgt_in_q[RAMP_WIDTH] <= s_axis_tdata[2*S +: GAIN_W];
      tgt_in_q[RAMP_SWAP]  <= s_axis_tdata[2*S+GAIN_W] ? GAIN_ONE : GAIN_ZERO;
      tgt_in_q[RAMP_MUTE]  <= s_axis_tdata[2*S+GAIN_W+1] ? GAIN_ZERO : GAIN_ONE;
      mono_q               <= s_axis_tuser;
    end
    if (state_q == ST_ADV) begin
      gain_q <= adv_gain;
      if (mono_q) begin
        lf_q <= mid_ext;
        rf_q <= '0;
      end
    end
    if (mul_done) begin
      unique case (state_q)
        ST_MUL1: p1_q <= mul_p;
        ST_MUL2: begin
          dl_q <= mid_ext + mul_p;
          dr_q <= mid_ext - mul_p;
        end
        ST_MUL3: lf_q <= dl_q + mul_p;
        ST_MUL4: rf_q <= dr_q + mul_p;
        default: p1_q <= p1_q;
      endcase
    end
    if (out_load) begin
      left_q  <= sat(lf_q);
      right_q <= sat(rf_q);
    end
  end

  msd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (cfg_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  msd_mul #(
    .DATA_W (W)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .g_i     (mul_g),
    .busy_o  (mul_busy),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TW'({right_q, left_q});

  assert property (@(posedge clk_i) disable iff (!rst_ni) in_fire |=> state_q == ST_AIM)
    else $error("accepted request did not start target update");
  assert property (@(posedge clk_i) disable iff (!rst_ni) mul_start |-> !mul_busy)
    else $error("multiplier started while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      mul_done |-> (state_q == ST_MUL1 || state_q == ST_MUL2 ||
                    state_q == ST_MUL3 || state_q == ST_MUL4))
    else $error("multiplier result outside a multiply step");
  assert property (@(posedge clk_i) disable iff (!rst_ni) div_done |-> state_q == ST_DIV)
    else $error("divider result outside the divide step");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_load |-> (!out_valid_q || m_axis_tready))
    else $error("output register overwritten while holding a result");

endmodule

`default_nettype wire

/* tb/mid_side_decoder_smoothed_checker.sv */
// Checker for the smoothed mid/side decoder: predicts each result and compares it.
`timescale 1ns / 1ps

module mid_side_decoder_smoothed_checker import msd_pkg::*; (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic [((2*SAMPLE_BITS_DEF+GAIN_W+2+7)/8)*8-1:0] in_tdata_i,
  input  logic                                       in_tuser_i,
  input  logic                                       in_tvalid_i,
  input  logic                                       in_tready_i,
  input  logic [((2*SAMPLE_BITS_DEF+7)/8)*8-1:0]     out_tdata_i,
  input  logic                                       out_tvalid_i,
  input  logic                                       out_tready_i,
  input  logic                                       cfg_we_i,
  input  logic [STEPS_W-1:0]                         cfg_wdata_i,
  output int                                         fail_count_o,
  output int                                         pending_o
);

  localparam int SB       = SAMPLE_BITS_DEF;
  localparam int IN_W     = ((2*SB+GAIN_W+2+7)/8)*8;
  localparam int OUT_W    = ((2*SB+7)/8)*8;
  localparam int WT_LSB   = 2*SB;
  localparam int SWAP_BIT = 2*SB + GAIN_W;
  localparam int MUTE_BIT = SWAP_BIT + 1;

  logic [STEPS_W-1:0] ramp_len;
  logic [CUR_W-1:0]   gain_now   [NUM_RAMPS];
  logic [GAIN_W-1:0]  gain_goal  [NUM_RAMPS];
  logic [CUR_W-1:0]   gain_slope [NUM_RAMPS];
  logic [STEPS_W-1:0] gain_left  [NUM_RAMPS];

  // Left sample in the low half, right sample above it, as on the output bus.
  logic [OUT_W-1:0]   expected_pairs[$];

  function automatic void retarget(input logic [RAMP_IDX_W-1:0] k,
                                   input logic [GAIN_W-1:0] goal);
    longint span;
    if (goal != gain_goal[k]) begin
      gain_goal[k] = goal;
      if (ramp_len == '0) begin
        gain_now[k]   = {goal, 16'h0000};
        gain_slope[k] = '0;
        gain_left[k]  = '0;
      end else begin
        gain_left[k]  = ramp_len;
        span          = longint'({goal, 16'h0000}) - longint'(gain_now[k]);
        span          = span / longint'(ramp_len);
        gain_slope[k] = span[CUR_W-1:0];
      end
    end
  endfunction

  // Moves one ramp on by a sample and returns the gain that it yields.
  function automatic logic [GAIN_W-1:0] step_gain(input logic [RAMP_IDX_W-1:0] k);
    if (gain_left[k] == '0) return gain_goal[k];
    gain_left[k] = gain_left[k] - 1'b1;
    if (gain_left[k] == '0) gain_now[k] = {gain_goal[k], 16'h0000};
    else gain_now[k] = gain_now[k] + gain_slope[k];
    return gain_now[k][CUR_W-1 -: GAIN_W];
  endfunction

  // Q2.14 product, rounded half up.
  function automatic longint gain_mul(input longint a, input logic [GAIN_W-1:0] g);
    longint p;
    p = a * longint'(g) + longint'(ROUND_BIAS);
    return p >>> GAIN_FRAC;
  endfunction

  function automatic logic [SB-1:0] clip(input longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (SB - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi[SB-1:0];
    if (v < lo) return lo[SB-1:0];
    return v[SB-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] decode_request(input logic [IN_W-1:0] d,
                                                      input logic mono);
    longint mid;
    longint side;
    longint s;
    longint dl;
    longint dr;
    logic [GAIN_W-1:0] w;
    logic [GAIN_W-1:0] m;
    logic [GAIN_W-1:0] sw;
    logic [OUT_W-1:0] pair;
    mid  = longint'(signed'(d[0 +: SB]));
    side = longint'(signed'(d[SB +: SB]));
    // Targets are taken in the order width, swap, mute; the ramps then step
    // in the order width, mute, swap.
    retarget(RAMP_WIDTH, d[WT_LSB +: GAIN_W]);
    retarget(RAMP_SWAP, d[SWAP_BIT] ? GAIN_ONE : GAIN_ZERO);
    retarget(RAMP_MUTE, d[MUTE_BIT] ? GAIN_ZERO : GAIN_ONE);
    w  = step_gain(RAMP_WIDTH);
    m  = step_gain(RAMP_MUTE);
    sw = step_gain(RAMP_SWAP);
    pair = '0;
    if (mono) begin
      pair[0 +: SB] = d[0 +: SB];
    end else begin
      s  = gain_mul(gain_mul(side, w), m);
      dl = mid + s;
      dr = mid - s;
      pair[0 +: SB]  = clip(dl + gain_mul(dr - dl, sw));
      pair[SB +: SB] = clip(dr + gain_mul(dl - dr, sw));
    end
    return pair;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [OUT_W-1:0] want;
    if (!rst_ni) begin
      ramp_len                = RAMP_STEPS_RESET;
      gain_goal[RAMP_WIDTH]   = WIDTH_RESET;
      gain_goal[RAMP_MUTE]    = GAIN_ONE;
      gain_goal[RAMP_SWAP]    = GAIN_ZERO;
      for (int k = 0; k < NUM_RAMPS; k++) begin
        gain_now[k]   = {gain_goal[k], 16'h0000};
        gain_slope[k] = '0;
        gain_left[k]  = '0;
      end
      expected_pairs.delete();
      fail_count_o = 0;
    end else begin
      if (out_tvalid_i && out_tready_i) begin
        if (expected_pairs.size() == 0) begin
          fail_count_o++;
          $display("%0t: result left %0d right %0d arrived with no request outstanding",
                   $time, $signed(out_tdata_i[0 +: SB]), $signed(out_tdata_i[SB +: SB]));
        end else begin
          want = expected_pairs.pop_front();
          if (out_tdata_i[0 +: SB] !== want[0 +: SB]) begin
            fail_count_o++;
            $display("%0t: left_sample expected %0d, got %0d", $time,
                     $signed(want[0 +: SB]), $signed(out_tdata_i[0 +: SB]));
          end
          if (out_tdata_i[SB +: SB] !== want[SB +: SB]) begin
            fail_count_o++;
            $display("%0t: right_sample expected %0d, got %0d", $time,
                     $signed(want[SB +: SB]), $signed(out_tdata_i[SB +: SB]));
          end
        end
      end
      if (cfg_we_i) ramp_len = cfg_wdata_i;
      if (in_tvalid_i && in_tready_i) expected_pairs.push_back(decode_request(in_tdata_i,
                                                                              in_tuser_i));
    end
    pending_o = expected_pairs.size();
  end

endmodule

/* tb/mid_side_decoder_smoothed_tb.sv */
// Testbench top for the smoothed mid/side decoder: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module mid_side_decoder_smoothed_tb import msd_pkg::*; ();

  localparam int SB           = SAMPLE_BITS_DEF;
  localparam int IN_W         = ((2*SB+GAIN_W+2+7)/8)*8;
  localparam int OUT_W        = ((2*SB+7)/8)*8;
  localparam int QUIET_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 150;
  localparam int PHASE_ITEMS  = 100;
  localparam int NUM_PHASES   = 8;

  localparam logic [SB-1:0]     SMP_MAX     = {1'b0, {(SB-1){1'b1}}};
  localparam logic [SB-1:0]     SMP_MIN     = {1'b1, {(SB-1){1'b0}}};
  localparam logic [GAIN_W-1:0] WIDTH_TWO   = 16'd32768;
  localparam logic [GAIN_W-1:0] WIDTH_TOP   = 16'hFFFF;
  localparam logic [GAIN_W-1:0] WIDTH_HALF  = 16'd8192;

  logic               clk_i;
  logic               rst_ni;
  logic [IN_W-1:0]    s_axis_tdata;
  logic               s_axis_tuser;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [OUT_W-1:0]   m_axis_tdata;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic               cfg_we_i;
  logic [STEPS_W-1:0] cfg_wdata_i;
  int                 fail_count;
  int                 pending;

  // Sticky control targets for the random part, so that ramps get to finish.
  logic [GAIN_W-1:0]  cur_width;
  logic               cur_swap;
  logic               cur_mute;
  bit                 src_paced;

  mid_side_decoder_smoothed u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  mid_side_decoder_smoothed_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_tdata_i   (s_axis_tdata),
    .in_tuser_i   (s_axis_tuser),
    .in_tvalid_i  (s_axis_tvalid),
    .in_tready_i  (s_axis_tready),
    .out_tdata_i  (m_axis_tdata),
    .out_tvalid_i (m_axis_tvalid),
    .out_tready_i (m_axis_tready),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [SB-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return SMP_MAX;
      1: return SMP_MIN;
      2: return SB'($urandom_range(0, 63) - 32);
      default: return SB'($urandom());
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_width();
    case ($urandom_range(0, 5))
      0: return GAIN_ZERO;
      1: return GAIN_ONE;
      2: return WIDTH_TWO;
      3: return WIDTH_TOP;
      default: return GAIN_W'($urandom());
    endcase
  endfunction

  // Offers one request and returns at the edge where it is taken. The valid
  // stays high afterwards, so back-to-back requests need no extra edge.
  task automatic send_request(input logic [SB-1:0] mid, input logic [SB-1:0] side,
                              input logic [GAIN_W-1:0] width, input logic swap,
                              input logic mute, input logic mono);
    int gap;
    logic [IN_W-1:0] word;
    gap = src_paced ? $urandom_range(0, 10) : 0;
    word = '0;
    word[0 +: SB]           = mid;
    word[SB +: SB]          = side;
    word[2*SB +: GAIN_W]    = width;
    word[2*SB + GAIN_W]     = swap;
    word[2*SB + GAIN_W + 1] = mute;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= word;
    s_axis_tuser  <= mono;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // The ramp length may only change once every request has come back.
  task automatic write_ramp_len(input logic [STEPS_W-1:0] len);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    cfg_wdata_i <= len;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Receiver: random stalls, calm stretches, and two long hold-offs that let
  // the block fill up and push back on its input.
  initial begin
    int gap;
    int taken;
    taken = 0;
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (taken == 300 || taken == 620) gap = HOLD_CYCLES;
      else if (((taken / 50) % 3) == 1) gap = 0;
      else gap = $urandom_range(0, 10);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      taken++;
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [STEPS_W-1:0] phase_len [NUM_PHASES];
    int item;
    rst_ni        <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    s_axis_tvalid <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    src_paced     = 1'b1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset state: targets equal to the reset gains start no ramp.
    send_request('0, SMP_MAX, WIDTH_RESET, 1'b0, 1'b0, 1'b0);
    send_request(SMP_MAX, SMP_MAX, WIDTH_RESET, 1'b0, 1'b0, 1'b0);
    send_request(SMP_MIN, SMP_MAX, WIDTH_RESET, 1'b0, 1'b0, 1'b0);

    // Zero ramp length: every new target is taken at once.
    write_ramp_len('0);
    send_request(SMP_MAX, SMP_MAX, WIDTH_TOP, 1'b0, 1'b0, 1'b0);
    send_request(SMP_MIN, SMP_MIN, WIDTH_TOP, 1'b0, 1'b0, 1'b0);
    send_request(SMP_MIN, SMP_MAX, WIDTH_TOP, 1'b1, 1'b0, 1'b0);
    send_request(SB'(12345), SB'(-23456), GAIN_ZERO, 1'b0, 1'b0, 1'b0);
    send_request(SMP_MAX, SMP_MIN, WIDTH_TWO, 1'b1, 1'b1, 1'b0);
    send_request(SMP_MIN, SMP_MAX, WIDTH_TWO, 1'b0, 1'b0, 1'b1);
    send_request(SMP_MAX, '0, GAIN_ZERO, 1'b1, 1'b1, 1'b1);
    // Rounding ties go toward plus infinity.
    send_request(SB'(-1), SB'(1), WIDTH_HALF, 1'b0, 1'b0, 1'b0);
    send_request('0, SB'(-1), WIDTH_HALF, 1'b0, 1'b0, 1'b0);

    // Short ramps on all three gains, with retargets in the middle of the width and mute ramps.
    write_ramp_len(12'd4);
    send_request(SB'(1000000), SB'(3000000), WIDTH_TWO, 1'b1, 1'b1, 1'b0);
    send_request(SB'(-2000000), SB'(3000000), WIDTH_TWO, 1'b1, 1'b1, 1'b0);
    send_request(SB'(1000000), SB'(-3000000), GAIN_ZERO, 1'b1, 1'b0, 1'b0);
    send_request(SB'(500000), SB'(3000000), GAIN_ZERO, 1'b1, 1'b0, 1'b0);
    send_request(SB'(500000), SB'(7000000), GAIN_ZERO, 1'b1, 1'b0, 1'b0);
    send_request(SB'(-500000), SB'(7000000), GAIN_ZERO, 1'b1, 1'b0, 1'b0);

    // A length change while ramps run leaves them on their old step.
    send_request(SB'(4000000), SB'(2000000), GAIN_ONE, 1'b0, 1'b1, 1'b0);
    write_ramp_len(12'd4095);
    send_request(SB'(4000000), SB'(2000000), GAIN_ONE, 1'b0, 1'b1, 1'b0);
    send_request(SB'(-4000000), SB'(2000000), GAIN_ONE, 1'b0, 1'b1, 1'b0);
    send_request(SB'(4000000), SB'(-2000000), WIDTH_TOP, 1'b0, 1'b1, 1'b0);
    send_request(SMP_MIN, SMP_MAX, WIDTH_TOP, 1'b0, 1'b1, 1'b1);

    phase_len[0] = 12'd2;
    phase_len[1] = '0;
    phase_len[2] = 12'd1;
    phase_len[3] = 12'd4095;
    phase_len[4] = 12'd5;
    phase_len[5] = STEPS_W'($urandom_range(1, 40));
    phase_len[6] = STEPS_W'($urandom());
    phase_len[7] = 12'd3;
    cur_width = WIDTH_TOP;
    cur_swap  = 1'b0;
    cur_mute  = 1'b1;
    item = 0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_ramp_len(phase_len[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        src_paced = ((item / 37) % 3) != 0;
        if ($urandom_range(0, 7) == 0) cur_width = pick_width();
        if ($urandom_range(0, 11) == 0) cur_swap = ~cur_swap;
        if ($urandom_range(0, 11) == 0) cur_mute = ~cur_mute;
        send_request(pick_sample(), pick_sample(), cur_width, cur_swap, cur_mute,
                     $urandom_range(0, 6) == 0);
        item++;
      end
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/msd_pkg.sv
hw/rtl/msd_div.sv
hw/rtl/msd_mul.sv
hw/rtl/mid_side_decoder_smoothed.sv
tb/mid_side_decoder_smoothed_checker.sv
tb/mid_side_decoder_smoothed_tb.sv
